>>> design/nbg_pkg.sv
// Shared types, constants and helper functions of the n-body gravity step unit.
package nbg_pkg;

  localparam int MAX_BODIES_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic [15:0] GAIN_RESET = 16'd6554;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 33;
  localparam int ACC_W = 41;
  localparam int SAT_IN_W = 42;

  typedef struct packed {
    logic start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic clip;
  } sat_t;

  typedef enum logic [4:0] {
    S_LOAD, S_OWN_RD, S_OWN_LATCH, S_PAIR_RD, S_PAIR_D,
    S_SQ_A, S_SQ_B, S_SQ_START, S_SQ_RUN, S_DIST, S_MR3, S_MG,
    S_DIV1, S_DIV1_W, S_DIV2, S_DIV2_W, S_DIVX, S_DIVX_W, S_DIVY, S_DIVY_W,
    S_TX, S_TX_ACC, S_TY_ACC, S_FINISH, S_OUT_RD, S_OUT_CALC, S_OUT_WAIT
  } state_t;

  function automatic sat_t sat32(input logic signed [SAT_IN_W-1:0] v);
    sat_t res;
    if (v > SAT_IN_W'(signed'(32'sh7FFFFFFF))) begin
      res.val = 32'sh7FFFFFFF;
      res.clip = 1'b1;
    end else if (v < SAT_IN_W'(signed'(32'sh80000000))) begin
      res.val = 32'sh80000000;
      res.clip = 1'b1;
    end else begin
      res.val = v[31:0];
      res.clip = 1'b0;
    end
    return res;
  endfunction

endpackage

>>> design/nbg_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions of a pair.
module nbg_div import nbg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  div_req_t req,
  output logic busy,
  output logic [DIV_NUM_W-1:0] quo
);

  logic [DIV_NUM_W-1:0] work;
  logic [DIV_DEN_W:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [6:0] cnt;
  logic [DIV_DEN_W+1:0] sh;
  logic ge;

  assign sh = {rem, work[DIV_NUM_W-1]};
  assign ge = sh >= {2'b00, den};
  assign quo = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 7'd1;
      if (cnt == 7'(DIV_NUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      work <= {work[DIV_NUM_W-2:0], ge};
      rem <= ge ? (DIV_DEN_W+1)'(sh - {2'b00, den}) : sh[DIV_DEN_W:0];
    end
  end

endmodule

>>> design/nbody_gravity_step_unit.sv
// Top level of the n-body gravity step unit: body store, sequencer and shared datapath.
// Bodies are loaded into the store; the body marked last starts the step. Each pair term
// uses a 32-step square root, four divisions on the shared divider and the shared multiplier.
// A coincident pair is skipped without a force term. Results then go out one body at a time,
// held while the output stalls; no body is taken while a step runs.
// Synchronous reset clears the sequencer and load count and sets the gain to its default.
module nbody_gravity_step_unit import nbg_pkg::*; #(
  parameter int MAX_BODIES = MAX_BODIES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // pos_x, pos_y, vel_x, vel_y, radius.
  input  logic [135:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // body_index, new_x, new_y, new_vx, new_vy, zero pad.
  output logic [135:0] m_axis_tdata,
  // saturated.
  output logic m_axis_tuser,
  output logic m_axis_tlast
);

  localparam int AW = $clog2(MAX_BODIES);
  localparam int CW = $clog2(MAX_BODIES + 1);
  localparam int K_ALL = 3 * FRAC_BITS - 16;
  localparam int K_ONE = K_ALL / 2;
  localparam int K_TWO = K_ALL - K_ONE;
  localparam logic [63:0] SHL_LIMIT = 64'd1 << 62;
  localparam logic [63:0] LIM_ONE = SHL_LIMIT >> K_ONE;
  localparam logic [63:0] LIM_TWO = SHL_LIMIT >> K_TWO;
  localparam logic [63:0] FORCE_CAP = 64'd1 << 32;

  state_t state, state_next;

  logic [15:0] gain;
  logic [CW-1:0] cnt, i, j;
  logic [AW-1:0] rd_addr;

  logic signed [31:0] mem_x [MAX_BODIES];
  logic signed [31:0] mem_y [MAX_BODIES];
  logic signed [31:0] mem_vx [MAX_BODIES];
  logic signed [31:0] mem_vy [MAX_BODIES];
  logic [7:0] mem_r [MAX_BODIES];
  logic [MAX_BODIES-1:0] sat_flags;
  logic signed [31:0] x_q, y_q, vx_q, vy_q;
  logic [7:0] r_q;

  logic signed [31:0] own_x, own_y, own_vx, own_vy;
  logic [32:0] ax, ay;
  logic negx, negy, wide_pair;
  logic [7:0] rad;
  logic [63:0] asq, sq_v, sq_r, sq_b, rb;
  logic [4:0] sq_cnt;
  logic [32:0] span;
  logic [63:0] f1;
  logic [32:0] f;
  logic [31:0] ux, uy;
  logic signed [ACC_W-1:0] sx, sy;
  logic sat_cur;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  div_req_t div_req;
  logic div_busy;
  logic [63:0] quo;

  logic signed [32:0] dx_c, dy_c;
  logic [32:0] ax_c, ay_c;
  logic [63:0] tx_full, ty_full;
  logic signed [ACC_W-1:0] tx_s, ty_s;
  logic [63:0] m_val, shl1, shl2;
  logic clip1, clip2;
  logic in_fire, last_i;
  sat_t nvx, nvy, npx, npy;

  logic [5:0] o_idx;
  logic signed [31:0] o_x, o_y, o_vx, o_vy;
  logic o_sat, o_final;

  nbg_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .busy(div_busy),
    .quo(quo)
  );

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign last_i = (i + CW'(1)) == cnt;

  assign dx_c = {x_q[31], x_q} - {own_x[31], own_x};
  assign dy_c = {y_q[31], y_q} - {own_y[31], own_y};
  assign ax_c = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
  assign ay_c = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);

  assign m_val = {24'd0, prod[39:0]};
  assign clip1 = m_val > LIM_ONE;
  assign shl1 = clip1 ? SHL_LIMIT : (m_val << K_ONE);
  assign clip2 = f1 > LIM_TWO;
  assign shl2 = clip2 ? SHL_LIMIT : (f1 << K_TWO);

  assign tx_full = prod + (f[32] ? {ux, 32'd0} : 64'd0);
  assign ty_full = prod + (f[32] ? {uy, 32'd0} : 64'd0);
  assign tx_s = negx ? -ACC_W'(tx_full[63:30]) : ACC_W'(tx_full[63:30]);
  assign ty_s = negy ? -ACC_W'(ty_full[63:30]) : ACC_W'(ty_full[63:30]);

  assign rb = sq_r + sq_b;

  assign nvx = sat32(SAT_IN_W'(own_vx) + SAT_IN_W'(sx));
  assign nvy = sat32(SAT_IN_W'(own_vy) + SAT_IN_W'(sy));
  assign npx = sat32(SAT_IN_W'(x_q) + SAT_IN_W'(vx_q));
  assign npy = sat32(SAT_IN_W'(y_q) + SAT_IN_W'(vy_q));

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: if (in_fire && s_axis_tlast) state_next = S_OWN_RD;
      S_OWN_RD: state_next = S_OWN_LATCH;
      S_OWN_LATCH: state_next = S_PAIR_RD;
      S_PAIR_RD: begin
        if (j == cnt) begin
          state_next = S_FINISH;
        end else if (j != i) begin
          state_next = S_PAIR_D;
        end
      end
      S_PAIR_D: state_next = (ax_c == '0 && ay_c == '0) ? S_PAIR_RD : S_SQ_A;
      S_SQ_A: state_next = S_SQ_B;
      S_SQ_B: state_next = S_SQ_START;
      S_SQ_START: state_next = S_SQ_RUN;
      S_SQ_RUN: if (sq_cnt == 5'd31) state_next = S_DIST;
      S_DIST: state_next = S_MR3;
      S_MR3: state_next = S_MG;
      S_MG: state_next = S_DIV1;
      S_DIV1: state_next = S_DIV1_W;
      S_DIV1_W: if (!div_busy) state_next = S_DIV2;
      S_DIV2: state_next = S_DIV2_W;
      S_DIV2_W: if (!div_busy) state_next = S_DIVX;
      S_DIVX: state_next = S_DIVX_W;
      S_DIVX_W: if (!div_busy) state_next = S_DIVY;
      S_DIVY: state_next = S_DIVY_W;
      S_DIVY_W: if (!div_busy) state_next = S_TX;
      S_TX: state_next = S_TX_ACC;
      S_TX_ACC: state_next = S_TY_ACC;
      S_TY_ACC: state_next = S_PAIR_RD;
      S_FINISH: state_next = last_i ? S_OUT_RD : S_OWN_RD;
      S_OUT_RD: state_next = S_OUT_CALC;
      S_OUT_CALC: state_next = S_OUT_WAIT;
      S_OUT_WAIT: begin
        if (m_axis_tready) begin
          state_next = o_final ? S_LOAD : S_OUT_RD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    s_axis_tready = state == S_LOAD;
    m_axis_tvalid = state == S_OUT_WAIT;
    rd_addr = (state == S_PAIR_RD) ? j[AW-1:0] : i[AW-1:0];
    mul_a = '0;
    mul_b = '0;
    div_req.start = 1'b0;
    div_req.num = '0;
    div_req.den = span;
    case (state)
      S_SQ_A: begin
        mul_a = wide_pair ? ax[32:1] : ax[31:0];
        mul_b = mul_a;
      end
      S_SQ_B: begin
        mul_a = wide_pair ? ay[32:1] : ay[31:0];
        mul_b = mul_a;
      end
      S_DIST: begin
        mul_a = 32'(rad);
        mul_b = 32'(rad);
      end
      S_MR3: begin
        mul_a = 32'(prod[15:0]);
        mul_b = 32'(rad);
      end
      S_MG: begin
        mul_a = 32'(prod[23:0]);
        mul_b = 32'(gain);
      end
      S_DIV1: begin
        div_req.start = 1'b1;
        div_req.num = shl1;
      end
      S_DIV2: begin
        div_req.start = 1'b1;
        div_req.num = shl2;
      end
      S_DIVX: begin
        div_req.start = 1'b1;
        div_req.num = {1'b0, ax, 30'd0};
      end
      S_DIVY: begin
        div_req.start = 1'b1;
        div_req.num = {1'b0, ay, 30'd0};
      end
      S_TX: begin
        mul_a = f[31:0];
        mul_b = ux;
      end
      S_TX_ACC: begin
        mul_a = f[31:0];
        mul_b = uy;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    x_q <= mem_x[rd_addr];
    y_q <= mem_y[rd_addr];
    vx_q <= mem_vx[rd_addr];
    vy_q <= mem_vy[rd_addr];
    r_q <= mem_r[rd_addr];
    if (in_fire && cnt < CW'(MAX_BODIES)) begin
      mem_x[cnt[AW-1:0]] <= s_axis_tdata[31:0];
      mem_y[cnt[AW-1:0]] <= s_axis_tdata[63:32];
      mem_vx[cnt[AW-1:0]] <= s_axis_tdata[95:64];
      mem_vy[cnt[AW-1:0]] <= s_axis_tdata[127:96];
      mem_r[cnt[AW-1:0]] <= s_axis_tdata[135:128];
    end
    if (state == S_FINISH) begin
      mem_vx[i[AW-1:0]] <= nvx.val;
      mem_vy[i[AW-1:0]] <= nvy.val;
      sat_flags[i[AW-1:0]] <= sat_cur | nvx.clip | nvy.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      gain <= GAIN_RESET;
      cnt <= '0;
      i <= '0;
      j <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        gain <= cfg_wr_data;
      end
      case (state)
        S_LOAD: begin
          i <= '0;
          if (in_fire && cnt < CW'(MAX_BODIES)) begin
            cnt <= cnt + CW'(1);
          end
        end
        S_OWN_LATCH: j <= '0;
        S_PAIR_RD: if (j == i) j <= j + CW'(1);
        S_PAIR_D: if (ax_c == '0 && ay_c == '0) j <= j + CW'(1);
        S_TY_ACC: j <= j + CW'(1);
        S_FINISH: i <= last_i ? '0 : i + CW'(1);
        S_OUT_WAIT: begin
          if (m_axis_tready) begin
            i <= i + CW'(1);
            if (o_final) begin
              cnt <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_OWN_LATCH: begin
        own_x <= x_q;
        own_y <= y_q;
        own_vx <= vx_q;
        own_vy <= vy_q;
        sx <= '0;
        sy <= '0;
        sat_cur <= 1'b0;
      end
      S_PAIR_D: begin
        ax <= ax_c;
        ay <= ay_c;
        negx <= dx_c[32];
        negy <= dy_c[32];
        wide_pair <= (ax_c[32:31] != 2'b00) || (ay_c[32:31] != 2'b00);
        rad <= r_q;
      end
      S_SQ_B: asq <= prod;
      S_SQ_START: begin
        sq_v <= asq + prod;
        sq_r <= '0;
        sq_b <= SHL_LIMIT;
        sq_cnt <= '0;
      end
      S_SQ_RUN: begin
        sq_cnt <= sq_cnt + 5'd1;
        sq_b <= sq_b >> 2;
        if (sq_v >= rb) begin
          sq_v <= sq_v - rb;
          sq_r <= (sq_r >> 1) + sq_b;
        end else begin
          sq_r <= sq_r >> 1;
        end
      end
      S_DIST: span <= wide_pair ? {sq_r[31:0], 1'b0} : sq_r[32:0];
      S_DIV1: if (clip1) sat_cur <= 1'b1;
      S_DIV1_W: f1 <= quo;
      S_DIV2: if (clip2) sat_cur <= 1'b1;
      S_DIV2_W: begin
        if (!div_busy) begin
          if (quo > FORCE_CAP) begin
            f <= FORCE_CAP[32:0];
            sat_cur <= 1'b1;
          end else begin
            f <= quo[32:0];
          end
        end
      end
      S_DIVX_W: ux <= quo[31:0];
      S_DIVY_W: uy <= quo[31:0];
      S_TX_ACC: sx <= sx + tx_s;
      S_TY_ACC: sy <= sy + ty_s;
      S_OUT_CALC: begin
        o_idx <= 6'(i);
        o_x <= npx.val;
        o_y <= npy.val;
        o_vx <= vx_q;
        o_vy <= vy_q;
        o_sat <= sat_flags[i[AW-1:0]] | npx.clip | npy.clip;
        o_final <= last_i;
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tdata = {2'b00, o_vy, o_vx, o_y, o_x, o_idx};
  assign m_axis_tuser = o_sat;
  assign m_axis_tlast = o_final;

  a_sides_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output both active");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  a_out_has_bodies: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> cnt != '0)
    else $error("result with empty body store");

  a_last_ends_step: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("step did not return to loading");

endmodule
